### hw/rtl/swse_pkg.sv
// ----------------------------------------------------------------------------
// swse_pkg: shared definitions for the string wave stencil engine
// Item codes, register indexes, field widths, reset values and the command
// word passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package swse_pkg;

    // Fixed field widths of the ports.
    localparam int FUNC_BITS      = 2;
    localparam int INDEX_BITS     = 10;
    localparam int IO_BITS        = 32;
    localparam int COEF_BITS      = 32;
    localparam int POINTS_BITS    = 11;
    localparam int CFG_INDEX_BITS = 1;

    // Defaults of the top-level parameters.
    localparam int MAX_POINTS_DEFAULT = 1024;
    localparam int VALUE_BITS_DEFAULT = 32;

    // Item codes.
    localparam logic [FUNC_BITS-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_STEP = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_READ = 2'd2;

    // Register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_COURANT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POINTS  = 1'd1;

    // Register reset values.
    localparam logic [COEF_BITS-1:0]   COURANT_RESET = 32'd858993;
    localparam logic [POINTS_BITS-1:0] POINTS_RESET  = 11'd1001;

    // Smallest grid that has an interior point.
    localparam logic [POINTS_BITS-1:0] POINTS_MIN = 11'd3;

    // Half of one unit of the Q0.32 product, for round to nearest.
    localparam logic [COEF_BITS-1:0] ROUND_HALF = 32'h8000_0000;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load_wr;   // write the load word into both rows
        logic item_rd;   // read the current row at the item's index
        logic rd_cap;    // capture the read data into the output register
        logic step_rd;   // sweep read of the current and previous rows
        logic calc;      // the sweep read completes an interior stencil
        logic zero_wr;   // write zero to an end point of the new row
        logic cur_b;     // row b holds the current displacement
    } cmd_t;

endpackage

### hw/rtl/string_wave_stencil_engine.sv
// ----------------------------------------------------------------------------
// string_wave_stencil_engine: leapfrog solver for a vibrating string
// Load, step and read words over two displacement rows held in memory.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall   func, point_index, load_value
//   output    out        out_valid / out_stall displacement, read_index
//   config    in         cfg_write             cfg_index, cfg_data
//
// A load word is written into both rows when it is accepted. A read word's
// result passes the read register of its row, then stands in the output
// register. A step word sweeps the n active points, reading one point per
// cycle from the memory ports, then the five-stage update pipeline drains.
// Reset clears control state only; the rows hold no reset value. A read
// word waits while an earlier result is still stalled in the output register.
// ----------------------------------------------------------------------------
module string_wave_stencil_engine
    import swse_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]      cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [FUNC_BITS-1:0]      func,
    input  logic [INDEX_BITS-1:0]     point_index,
    input  logic signed [IO_BITS-1:0] load_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [IO_BITS-1:0] displacement,
    output logic [INDEX_BITS-1:0]     read_index
);

    localparam int AW = $clog2(MAX_POINTS);

    cmd_t          cmd;
    logic          busy;
    logic [AW-1:0] step_addr;
    logic [AW-1:0] end_addr;

    swse_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .busy      (busy),
        .cmd       (cmd),
        .step_addr (step_addr),
        .end_addr  (end_addr)
    );

    swse_dp #(
        .MAX_POINTS (MAX_POINTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_index  (point_index),
        .load_value   (load_value),
        .cmd          (cmd),
        .step_addr    (step_addr),
        .end_addr     (end_addr),
        .displacement (displacement),
        .read_index   (read_index),
        .busy         (busy)
    );

endmodule

### hw/rtl/swse_ctrl.sv
// ----------------------------------------------------------------------------
// swse_ctrl: controller of the string wave stencil engine
// Accepts items, sequences the sweep of a time step, tracks which row is
// current and owns the output valid flag and the grid size register.
// ----------------------------------------------------------------------------
module swse_ctrl
    import swse_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [COEF_BITS-1:0]         cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [FUNC_BITS-1:0]         func,
    output logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         busy,
    output cmd_t                         cmd,
    output logic [$clog2(MAX_POINTS)-1:0] step_addr,
    output logic [$clog2(MAX_POINTS)-1:0] end_addr
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    state_t                 state_reg;
    logic [AW-1:0]          k_reg;
    logic [NW-1:0]          n_reg;
    logic [NW-1:0]          n_next;
    logic                   cur_b_reg;
    logic                   out_valid_reg;
    logic [POINTS_BITS-1:0] points_reg;
    logic                   accept;
    logic                   last_point;

    assign in_stall = (state_reg != ST_IDLE) || ((func == FUNC_READ) && out_valid_reg);
    assign accept   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // Grid size clamped between POINTS_MIN and the number of points the memories can hold.
    always_comb
    begin
        if (points_reg < POINTS_MIN)
        begin
            n_next = NW'(POINTS_MIN);
        end
        else if (32'(points_reg) > 32'(MAX_POINTS))
        begin
            n_next = NW'(MAX_POINTS);
        end
        else
        begin
            n_next = NW'(points_reg);
        end
    end

    assign last_point = (NW'(k_reg) == (n_reg - NW'(1)));
    assign step_addr  = k_reg;
    assign end_addr   = (k_reg == '0) ? '0 : AW'(n_reg - NW'(1));

    always_comb
    begin
        cmd         = '0;
        cmd.cur_b   = cur_b_reg;
        cmd.load_wr = accept && (func == FUNC_LOAD);
        cmd.item_rd = accept && (func == FUNC_READ);
        cmd.rd_cap  = (state_reg == ST_RD_WAIT);
        if (state_reg == ST_ISSUE)
        begin
            cmd.step_rd = 1'b1;
            cmd.calc    = (k_reg >= AW'(2));
            // Both end points are written early; they are never read as
            // previous values, so the sweep cannot see them.
            cmd.zero_wr = (k_reg < AW'(2));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            n_reg         <= NW'(POINTS_MIN);
            cur_b_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            points_reg    <= POINTS_RESET;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_POINTS))
            begin
                points_reg <= cfg_data[POINTS_BITS-1:0];
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (func == FUNC_READ))
                    begin
                        state_reg <= ST_RD_WAIT;
                    end
                    else if (accept && (func == FUNC_STEP))
                    begin
                        k_reg     <= '0;
                        n_reg     <= n_next;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_RD_WAIT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                ST_ISSUE:
                begin
                    if (last_point)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + AW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!busy)
                    begin
                        cur_b_reg <= ~cur_b_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/swse_dp.sv
// ----------------------------------------------------------------------------
// swse_dp: datapath of the string wave stencil engine
// Holds both displacement rows, the stencil window and the five-stage
// update pipeline, the coefficient register and the output word.
// ----------------------------------------------------------------------------
module swse_dp
    import swse_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [COEF_BITS-1:0]          cfg_data,
    input  logic [INDEX_BITS-1:0]         point_index,
    input  logic signed [IO_BITS-1:0]     load_value,
    input  cmd_t                          cmd,
    input  logic [$clog2(MAX_POINTS)-1:0] step_addr,
    input  logic [$clog2(MAX_POINTS)-1:0] end_addr,
    output logic signed [IO_BITS-1:0]     displacement,
    output logic [INDEX_BITS-1:0]         read_index,
    output logic                          busy
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int VB  = VALUE_BITS;
    localparam int LOB = (VB + 2) / 2;          // low slice of the magnitude
    localparam int HIB = VB + 1 - LOB;          // high slice of the magnitude
    localparam int TW  = LOB + COEF_BITS + 1;   // low product plus rounding
    localparam int PW  = HIB + COEF_BITS;       // high product
    localparam int SW  = VB + COEF_BITS + 2;    // full rounded product
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (VB - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
    localparam logic signed [63:0] OMAX = 64'sd2147483647;
    localparam logic signed [63:0] OMIN = -OMAX - 64'sd1;

    function automatic logic [VB-1:0] sat_value(input logic signed [63:0] v);
        logic [VB-1:0] r;
        if (v > VMAX)
        begin
            r = VMAX[VB-1:0];
        end
        else if (v < VMIN)
        begin
            r = VMIN[VB-1:0];
        end
        else
        begin
            r = v[VB-1:0];
        end
        return r;
    endfunction

    logic [VB-1:0] row_a_mem [MAX_POINTS];
    logic [VB-1:0] row_b_mem [MAX_POINTS];

    logic [COEF_BITS-1:0] coef_reg;

    logic [AW-1:0]  load_addr;
    logic           in_range;
    logic [VB-1:0]  load_word;
    logic [AW-1:0]  cur_addr;
    logic [AW-1:0]  prv_addr;
    logic [AW-1:0]  ra_a;
    logic [AW-1:0]  ra_b;
    logic [VB-1:0]  rd_a_reg;
    logic [VB-1:0]  rd_b_reg;
    logic signed [VB-1:0] cur_data;
    logic signed [VB-1:0] prv_data;

    logic           we_nxt;
    logic [AW-1:0]  wa_nxt;
    logic [VB-1:0]  wd_nxt;
    logic           we_a;
    logic           we_b;
    logic [AW-1:0]  wa_a;
    logic [AW-1:0]  wa_b;
    logic [VB-1:0]  wd_a;
    logic [VB-1:0]  wd_b;

    // Stencil window and pipeline registers.
    logic                  rd1_reg;
    logic                  v1_reg;
    logic [AW-1:0]         a1_reg;
    logic signed [VB-1:0]  c0_reg;
    logic signed [VB-1:0]  c1_reg;

    logic signed [VB+1:0]  lap;
    logic signed [VB+1:0]  lap_neg;
    logic signed [VB+1:0]  base;

    logic                  v2_reg;
    logic                  neg2_reg;
    logic [VB:0]           mag2_reg;
    logic signed [VB+1:0]  base2_reg;
    logic [AW-1:0]         a2_reg;

    logic [LOB+COEF_BITS-1:0] prod_lo;
    logic                  v3_reg;
    logic                  neg3_reg;
    logic [HIB-1:0]        hi3_reg;
    logic [TW-1:0]         t3_reg;
    logic signed [VB+1:0]  base3_reg;
    logic [AW-1:0]         a3_reg;

    logic [PW-1:0]         prod_hi;
    logic                  v4_reg;
    logic                  neg4_reg;
    logic [PW-1:0]         ph4_reg;
    logic [TW-1:0]         t4_reg;
    logic signed [VB+1:0]  base4_reg;
    logic [AW-1:0]         a4_reg;

    logic [SW-1:0]         sum4;
    logic                  v5_reg;
    logic                  neg5_reg;
    logic [VB+1:0]         q5_reg;
    logic signed [VB+1:0]  base5_reg;
    logic [AW-1:0]         a5_reg;

    logic signed [VB+2:0]  q_signed;
    logic signed [VB+2:0]  new_sum;
    logic [VB-1:0]         new_word;

    logic                  inr_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic signed [IO_BITS-1:0] disp_reg;

    assign load_addr = AW'(point_index);
    assign in_range  = (32'(point_index) < 32'(MAX_POINTS));
    assign load_word = sat_value(64'(load_value));

    // Address and data routing: the current row is read at the sweep or item
    // address, the other row at the point behind the sweep and written there.
    assign cur_addr = cmd.item_rd ? load_addr : step_addr;
    assign prv_addr = step_addr - AW'(1);
    assign ra_a     = cmd.cur_b ? prv_addr : cur_addr;
    assign ra_b     = cmd.cur_b ? cur_addr : prv_addr;
    assign cur_data = cmd.cur_b ? rd_b_reg : rd_a_reg;
    assign prv_data = cmd.cur_b ? rd_a_reg : rd_b_reg;

    assign we_nxt = v5_reg || cmd.zero_wr;
    assign wa_nxt = v5_reg ? a5_reg : end_addr;
    assign wd_nxt = v5_reg ? new_word : '0;

    assign we_a = (cmd.load_wr && in_range) || (cmd.cur_b && we_nxt);
    assign we_b = (cmd.load_wr && in_range) || (!cmd.cur_b && we_nxt);
    assign wa_a = cmd.load_wr ? load_addr : wa_nxt;
    assign wa_b = cmd.load_wr ? load_addr : wa_nxt;
    assign wd_a = cmd.load_wr ? load_word : wd_nxt;
    assign wd_b = cmd.load_wr ? load_word : wd_nxt;

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            row_a_mem[wa_a] <= wd_a;
        end
        rd_a_reg <= row_a_mem[ra_a];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            row_b_mem[wa_b] <= wd_b;
        end
        rd_b_reg <= row_b_mem[ra_b];
    end

    // Stage 1: laplacian and the 2*mid - prev term.
    assign lap = (VB+2)'(cur_data) + (VB+2)'(c0_reg) - ((VB+2)'(c1_reg) <<< 1);
    assign lap_neg = -lap;
    assign base = ((VB+2)'(c1_reg) <<< 1) - (VB+2)'(prv_data);

    // Stage 2 and 3: the magnitude times r in two slices.
    assign prod_lo = (LOB+COEF_BITS)'(mag2_reg[LOB-1:0]) * (LOB+COEF_BITS)'(coef_reg);
    assign prod_hi = PW'(hi3_reg) * PW'(coef_reg);

    // Stage 4: recombine the slices and drop the 32 fraction bits.
    assign sum4 = {1'b0, ph4_reg, {LOB{1'b0}}} + SW'(t4_reg);

    // Stage 5: signed sum and saturation.
    assign q_signed = signed'({1'b0, q5_reg});
    assign new_sum  = neg5_reg ? ((VB+3)'(base5_reg) - q_signed)
                               : ((VB+3)'(base5_reg) + q_signed);
    assign new_word = sat_value(64'(new_sum));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COURANT_RESET;
            rd1_reg  <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_COURANT))
            begin
                coef_reg <= cfg_data;
            end
            rd1_reg <= cmd.step_rd;
            v1_reg  <= cmd.calc;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg <= step_addr;
        if (rd1_reg)
        begin
            c1_reg <= cur_data;
            c0_reg <= c1_reg;
        end

        neg2_reg  <= lap[VB+1];
        mag2_reg  <= lap[VB+1] ? lap_neg[VB:0] : lap[VB:0];
        base2_reg <= base;
        a2_reg    <= a1_reg - AW'(1);

        neg3_reg  <= neg2_reg;
        hi3_reg   <= mag2_reg[VB:LOB];
        t3_reg    <= {1'b0, prod_lo} + TW'(ROUND_HALF);
        base3_reg <= base2_reg;
        a3_reg    <= a2_reg;

        neg4_reg  <= neg3_reg;
        ph4_reg   <= prod_hi;
        t4_reg    <= t3_reg;
        base4_reg <= base3_reg;
        a4_reg    <= a3_reg;

        neg5_reg  <= neg4_reg;
        q5_reg    <= sum4[SW-1:COEF_BITS];
        base5_reg <= base4_reg;
        a5_reg    <= a4_reg;

        if (cmd.item_rd)
        begin
            idx_reg <= point_index;
            inr_reg <= in_range;
        end
        if (cmd.rd_cap)
        begin
            if (!inr_reg)
            begin
                disp_reg <= '0;
            end
            else if (64'(cur_data) > OMAX)
            begin
                disp_reg <= OMAX[IO_BITS-1:0];
            end
            else if (64'(cur_data) < OMIN)
            begin
                disp_reg <= OMIN[IO_BITS-1:0];
            end
            else
            begin
                disp_reg <= IO_BITS'(64'(cur_data));
            end
        end
    end

    assign busy         = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg;
    assign displacement = disp_reg;
    assign read_index   = idx_reg;

endmodule
